>>> rtl/los_pkg.sv
// ----------------------------------------------------------------------------
// los_pkg
// Shared constants for the largest owned square search: field widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package los_pkg;

   // Payload and register field widths.
   localparam int OwnerWidth  = 5;
   localparam int TargetWidth = 4;
   localparam int SideWidth   = 6;
   localparam int ResultWidth = 6;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 1;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   localparam csr_index_type CSR_TARGET_OWNER = 1'd0;
   localparam csr_index_type CSR_BOARD_SIDE   = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [TargetWidth-1:0] TargetOwnerReset = 4'd0;
   localparam logic [SideWidth-1:0]   BoardSideReset   = 6'd20;

   // Largest value the result field can show.
   localparam logic [ResultWidth-1:0] ResultMax = 6'd63;

endpackage

>>> rtl/largest_owned_square.sv
// ----------------------------------------------------------------------------
// largest_owned_square
// Streaming maximal-square search over a raster-ordered grid of owner ids,
// reporting the side of the largest square owned by the target id per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  req_      in         valid / stall      cell_owner (5 bits, signed)
//  rsp_      out        valid / stall      largest_side (6 bits)
//  csr_      in         valid / ready      index (1 bit), wdata (6 bits)
//
//  One cell is accepted per clock unless the input stalls. Each cell reads
//  the line-buffer memory at accept and computes and writes its size back
//  in stage one. The result loads as stage one passes a frame's last cell.
//  Reset clears the counters, the running best, the line-buffer valid bits
//  and the registers; the memory itself needs no clearing pass.
//  Input stalls only while the last cell of a frame waits on a full,
//  stalled result register.
//
module largest_owned_square #(
   parameter int MAX_SIDE = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Cell request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [los_pkg::OwnerWidth-1:0] req_cell_owner,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [los_pkg::ResultWidth-1:0]    rsp_largest_side,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  los_pkg::csr_index_type             csr_index,
   input  logic [los_pkg::SideWidth-1:0]      csr_wdata
);
   import los_pkg::*;

   // Column address width and size width (sizes reach MAX_SIDE).
   localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = $clog2(MAX_SIDE + 1);

   // Configuration registers.
   logic [TargetWidth-1:0] target_owner_ff;
   logic [SideWidth-1:0]   board_side_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_owner_ff <= TargetOwnerReset;
         board_side_ff   <= BoardSideReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TARGET_OWNER: target_owner_ff <= csr_wdata[TargetWidth-1:0];
            CSR_BOARD_SIDE:   board_side_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective side: zero acts as one, values above MAX_SIDE are clamped.
   logic [6:0]    side_ext;
   logic [SW-1:0] side_eff;

   assign side_ext = {1'b0, board_side_ff};

   always_comb begin
      priority if (board_side_ff == '0) begin
         side_eff = SW'(1);
      end else if (side_ext > 7'(MAX_SIDE)) begin
         side_eff = SW'(MAX_SIDE);
      end else begin
         side_eff = SW'(side_ext);
      end
   end

   // Pipeline control.
   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff;
   logic s1_advance;
   logic req_accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall  = s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall;
   assign s1_advance = s1_valid_ff && !req_stall;
   assign req_accept = req_valid && !req_stall;

   // Raster counters, advanced at each accepted request.
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic          col_wrap;
   logic          row_wrap;

   assign col_wrap = (SW'(col_ff) + SW'(1)) >= side_eff;
   assign row_wrap = (SW'(row_ff) + SW'(1)) >= side_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one payload: position flags and match result of the request.
   logic [CW-1:0] s1_addr_ff;
   logic          s1_match_ff;
   logic          s1_has_row_ff;
   logic          s1_has_col_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff    <= col_ff;
         s1_match_ff   <= !req_cell_owner[OwnerWidth-1]
                          && (req_cell_owner[TargetWidth-1:0] == target_owner_ff);
         s1_has_row_ff <= (row_ff != '0);
         s1_has_col_ff <= (col_ff != '0);
         s1_last_ff    <= col_wrap && row_wrap;
      end
   end

   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Line buffer: one size per column, read at accept, written at commit.
   logic [SW-1:0]       above_mem [MAX_SIDE];
   logic [SW-1:0]       above_rd_ff;
   logic [MAX_SIDE-1:0] above_vld_ff;
   logic                above_rd_vld_ff;
   logic                fwd_hit_ff;
   logic [SW-1:0]       fwd_data_ff;
   logic [SW-1:0]       cur_size;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         above_mem[s1_addr_ff] <= cur_size;
      end
      if (req_accept) begin
         above_rd_ff <= above_mem[col_ff];
      end
   end

   // Valid bits stand in for the all-zero reset of the line buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         above_vld_ff <= '0;
      end else if (s1_advance) begin
         above_vld_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // Forward a write that lands on the entry being read in the same cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         above_rd_vld_ff <= above_vld_ff[col_ff];
         fwd_hit_ff      <= s1_advance && (s1_addr_ff == col_ff);
         fwd_data_ff     <= cur_size;
      end
   end

   // Stage one: neighbor sizes and the min-and-add step.
   logic [SW-1:0] left_ff;
   logic [SW-1:0] diag_ff;
   logic [SW-1:0] above_size;
   logic [SW-1:0] left_size;
   logic [SW-1:0] diag_size;
   logic [SW-1:0] min_ab;
   logic [SW-1:0] min_all;

   always_comb begin
      priority if (!s1_has_row_ff) begin
         above_size = '0;
      end else if (fwd_hit_ff) begin
         above_size = fwd_data_ff;
      end else if (above_rd_vld_ff) begin
         above_size = above_rd_ff;
      end else begin
         above_size = '0;
      end
   end

   assign left_size = s1_has_col_ff ? left_ff : '0;
   assign diag_size = (s1_has_col_ff && s1_has_row_ff) ? diag_ff : '0;
   assign min_ab    = (above_size < left_size) ? above_size : left_size;
   assign min_all   = (min_ab < diag_size) ? min_ab : diag_size;
   assign cur_size  = s1_match_ff ? min_all + SW'(1) : '0;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         left_ff <= cur_size;
         diag_ff <= above_size;
      end
   end

   // Running best of the frame, cleared when the frame's last cell loads the result.
   logic [SW-1:0] best_ff, best_in;
   logic [SW-1:0] best_now;

   assign best_now = (cur_size > best_ff) ? cur_size : best_ff;

   always_comb begin
      best_in = best_ff;
      if (s1_advance) begin
         best_in = s1_last_ff ? '0 : best_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   // Result register, saturated to the field width.
   logic [ResultWidth-1:0] rsp_side_ff;
   logic [7:0]             best_wide;

   assign best_wide = 8'(best_now);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_side_ff <= (best_wide > 8'(ResultMax)) ? ResultMax
                                                    : best_wide[ResultWidth-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_side = rsp_side_ff;

   // Checks on the pipeline and the frame bookkeeping.
   a_stall_only_on_last : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff))
      else $error("request stalled without a pending frame result");

   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (rsp_valid_ff && best_ff == '0))
      else $error("frame end did not load the result and clear the best");

   a_best_grows : assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_last_ff) |=> (best_ff >= $past(best_ff)))
      else $error("running best decreased within a frame");

   a_result_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (8'(rsp_side_ff) <= 8'(MAX_SIDE)))
      else $error("result exceeds the largest grid side");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the largest owned square search. Frames of owner
// ids are streamed into the block while a local scoring model tracks the
// square sizes per cell and queues the best side expected at each frame end.
// Results are compared in order. Sender gaps and receiver stalls are varied
// per phase; the board size changes between frames and in the middle of
// frames, the target owner only between frames.
// ----------------------------------------------------------------------------
module tb_top;
   import los_pkg::*;

   localparam int MaxSide     = 32;
   localparam int IdleSettle  = 8;
   localparam int HoldOffLong = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   logic signed [OwnerWidth-1:0] req_cell_owner = '0;
   logic                         rsp_valid;
   logic                         rsp_stall      = 1'b0;
   logic [ResultWidth-1:0]       rsp_largest_side;
   logic                         csr_valid      = 1'b0;
   logic                         csr_ready;
   csr_index_type                csr_index      = CSR_TARGET_OWNER;
   logic [SideWidth-1:0]         csr_wdata      = '0;

   // Requests waiting to be offered, and frame results still owed.
   logic signed [OwnerWidth-1:0] cell_queue[$];
   logic [ResultWidth-1:0]       expected_sides[$];

   // Random idling control, set per phase.
   int idle_pct     = 0;
   int stall_pct    = 0;
   int holdoff_left = 0;
   int mismatches   = 0;

   // Scoring model state: configuration, line buffer, neighbors, position.
   logic [TargetWidth-1:0] target_now = TargetOwnerReset;
   logic [SideWidth-1:0]   side_now   = BoardSideReset;
   logic [ResultWidth-1:0] line_sizes[MaxSide];
   logic [ResultWidth-1:0] left_prev  = '0;
   logic [ResultWidth-1:0] diag_prev  = '0;
   logic [ResultWidth-1:0] best_now   = '0;
   int unsigned            col_at     = 0;
   int unsigned            row_at     = 0;

   initial begin
      foreach (line_sizes[i]) line_sizes[i] = '0;
   end

   largest_owned_square #(
      .MAX_SIDE(MaxSide)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_owner   (req_cell_owner),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_largest_side (rsp_largest_side),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one cell to the tail of the pending request queue.
   function automatic void add_cell(logic signed [OwnerWidth-1:0] owner);
      cell_queue.insert(cell_queue.size(), owner);
   endfunction

   // Append one owed frame result to the tail of the expectation queue.
   function automatic void add_expected(logic [ResultWidth-1:0] side_val);
      expected_sides.insert(expected_sides.size(), side_val);
   endfunction

   // A board side of zero behaves as one; sides past the buffer are clipped.
   function automatic int unsigned effective_side();
      if (side_now == 0) return 1;
      if (side_now > MaxSide) return MaxSide;
      return side_now;
   endfunction

   // Square size of one cell from its three neighbors, then advance the raster
   // position. The frame's best side is owed once the last cell is seen.
   function automatic void score_cell(logic signed [OwnerWidth-1:0] owner);
      int unsigned            side;
      int unsigned            slot;
      logic [ResultWidth-1:0] up, lf, dg, low, size;
      side = effective_side();
      slot = (col_at >= MaxSide) ? MaxSide - 1 : col_at;
      up   = (row_at > 0) ? line_sizes[slot] : '0;
      lf   = (col_at > 0) ? left_prev : '0;
      dg   = (col_at > 0 && row_at > 0) ? diag_prev : '0;
      low  = (up < lf) ? up : lf;
      if (dg < low) low = dg;
      // Negative owners never match, whatever their low bits hold.
      size = (!owner[OwnerWidth-1] && owner[TargetWidth-1:0] == target_now) ?
             low + 1'b1 : '0;
      if (size > best_now) best_now = size;
      diag_prev        = up;
      left_prev        = size;
      line_sizes[slot] = size;
      // A position at or past a shrunken side wraps at the next cell.
      if (col_at + 1 >= side) begin
         col_at = 0;
         if (row_at + 1 >= side) begin
            row_at = 0;
            // Sizes cannot exceed the buffer depth, so no saturation is seen.
            add_expected(best_now);
            best_now = '0;
         end else begin
            row_at++;
         end
      end else begin
         col_at++;
      end
   endfunction

   // Cells still needed to close the current frame, from the idle position.
   function automatic int cells_left_in_frame();
      int unsigned side, c, r;
      int          n;
      bit          done;
      side = effective_side();
      c    = col_at;
      r    = row_at;
      n    = 0;
      done = 1'b0;
      while (!done) begin
         n++;
         if (c + 1 >= side) begin
            c = 0;
            if (r + 1 >= side) done = 1'b1;
            else r++;
         end else begin
            c++;
         end
      end
      return n;
   endfunction

   // Queue random cells; density is the percentage that carry the target id.
   task automatic queue_cells(int count, int density);
      repeat (count) begin
         if ($urandom_range(0, 99) < density)
            add_cell({1'b0, target_now});
         else
            add_cell(OwnerWidth'($urandom_range(0, 31)));
      end
   endtask

   // Wait until every request is taken and every result is back, then let the
   // pipeline settle so a mid-frame cell is fully written before a config write.
   task automatic wait_idle();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || expected_sides.size() != 0);
      repeat (IdleSettle) @(negedge clock);
   endtask

   // Register write; the model takes the new value at the handshake edge.
   task automatic write_csr(csr_index_type index, logic [SideWidth-1:0] data);
      @(posedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_TARGET_OWNER) target_now = data[TargetWidth-1:0];
      else if (index == CSR_BOARD_SIDE) side_now = data;
      @(negedge clock);
   endtask

   // Request driver: score each accepted cell, then offer the next or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) score_cell(req_cell_owner);
         if (!req_valid || !req_stall) begin
            if (cell_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid      <= 1'b1;
               req_cell_owner <= cell_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: a counted hold-off when one is pending, else random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Result monitor: compare each accepted result with the oldest expectation.
   logic [ResultWidth-1:0] side_wanted;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sides.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d",
                     $time, rsp_largest_side);
            mismatches++;
         end else begin
            side_wanted = expected_sides.pop_front();
            if (rsp_largest_side !== side_wanted) begin
               $display("%0t: largest_side mismatch: expected %0d, actual %0d",
                        $time, side_wanted, rsp_largest_side);
               mismatches++;
            end
         end
      end
   end

   int idle_table[4]  = '{0, 54, 0, 36};
   int stall_table[4] = '{0, 0, 54, 36};

   initial begin : stimulus
      int                   mode, grp, n, k, density;
      int unsigned          side;
      logic [SideWidth-1:0] pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-cell frames: negative owners whose low bits equal the target.
      write_csr(CSR_TARGET_OWNER, 6'd15);
      write_csr(CSR_BOARD_SIDE, 6'd1);
      add_cell(-5'sd1);
      add_cell(5'sd15);
      wait_idle();

      // A side of zero acts as one.
      write_csr(CSR_TARGET_OWNER, 6'd0);
      write_csr(CSR_BOARD_SIDE, 6'd0);
      add_cell(-5'sd16);
      add_cell(5'sd0);
      wait_idle();

      // Two by two: a full square, then one with a hole.
      write_csr(CSR_TARGET_OWNER, 6'd15);
      write_csr(CSR_BOARD_SIDE, 6'd2);
      repeat (4) add_cell(5'sd15);
      add_cell(5'sd15);
      add_cell(-5'sd1);
      add_cell(5'sd15);
      add_cell(5'sd15);
      wait_idle();

      // Three by three with the corner cell owned by someone else.
      write_csr(CSR_TARGET_OWNER, 6'd7);
      write_csr(CSR_BOARD_SIDE, 6'd3);
      repeat (8) add_cell(5'sd7);
      add_cell(5'sd3);

      for (mode = 0; mode < 4; mode++) begin
         wait_idle();
         idle_pct  = idle_table[mode];
         stall_pct = stall_table[mode];

         // Long receiver hold-off on small frames so the input backs up.
         if (mode == 0) begin
            write_csr(CSR_BOARD_SIDE, 6'd2);
            holdoff_left = HoldOffLong;
            queue_cells(cells_left_in_frame() + 36, 80);
            wait_idle();
         end

         // One full-size frame: an oversized side is clipped to the buffer.
         if (mode == 1) begin
            write_csr(CSR_BOARD_SIDE, 6'd63);
            queue_cells(cells_left_in_frame(), 100);
            wait_idle();
         end

         for (grp = 0; grp < 5; grp++) begin
            wait_idle();
            pick = SideWidth'($urandom_range(0, 63));
            write_csr(CSR_TARGET_OWNER, pick);
            pick = SideWidth'($urandom_range(0, 7));
            write_csr(CSR_BOARD_SIDE, pick);
            density = $urandom_range(40, 100);
            n = cells_left_in_frame();
            // Now and then the side changes partway through a frame.
            if ($urandom_range(0, 3) == 0 && n > 1) begin
               k = $urandom_range(1, n - 1);
               queue_cells(k, density);
               wait_idle();
               pick = SideWidth'($urandom_range(0, 7));
               write_csr(CSR_BOARD_SIDE, pick);
               n = cells_left_in_frame();
            end
            queue_cells(n, density);
            side = effective_side();
            repeat ($urandom_range(0, 3)) queue_cells(side * side, density);
         end
      end

      wait_idle();
      if (mismatches == 0 && expected_sides.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
